/* rtl/ratc_pkg.sv */
package ratc_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_COUNT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage

/* rtl/ratc_mem.sv */
module ratc_mem import ratc_pkg::*; #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [31:0]      wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [31:0]      rdata
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/range_add_threshold_count.sv */
// channel   direction  signals
// cfg       in         cfg_we, cfg_data (active_length)
// in        in         in_valid/in_ready, func, index_lo, index_hi, operand
// out       out        out_valid/out_ready, match_count
//
// one item at a time: the range is walked one entry per visit by a shared
// adder/comparator against a table ram with registered read; each entry passes
// through the read, wait and exec states; a load is written while idle
// reset clears control and sets active_length to min(depth, 1024); no clear pass
// in_ready stays low from a count or non-empty add transfer until the walk ends
// and any result transfer completes; a stalled result holds off the input
module range_add_threshold_count import ratc_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [9:0]  index_lo,
  input  logic [9:0]  index_hi,
  input  logic [31:0] operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] match_count
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t      state, state_next;
  logic [10:0] active_length;
  logic [10:0] cur, last;      // walk pointer and clipped end
  logic [1:0]  op;
  logic [31:0] opnd;
  logic [10:0] count;
  logic [31:0] rdata;
  logic        mem_we;
  logic [31:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic        empty;
  logic [10:0] hi_clip;

  // clip the incoming range against the active length
  always_comb begin
    hi_clip = ({1'b0, index_hi} >= active_length) ? active_length - 11'd1
                                                   : {1'b0, index_hi};
    empty = ({1'b0, index_lo} >= active_length) || (index_lo > index_hi);
  end

  // active length register, clamped into 1..TABLE_DEPTH
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= (TABLE_DEPTH < 1024) ? 11'(TABLE_DEPTH) : 11'd1024;
    end else if (cfg_we) begin
      if (cfg_data == 11'd0) active_length <= 11'd1;
      else if (32'(cfg_data) > 32'(TABLE_DEPTH)) active_length <= 11'(TABLE_DEPTH);
      else active_length <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_LOAD || func == FUNC_NONE) state_next = ST_IDLE;
          else if (empty) state_next = (func == FUNC_COUNT) ? ST_DONE : ST_IDLE;
          else state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_EXEC;
      ST_EXEC: begin
        if (cur == last) state_next = (op == FUNC_COUNT) ? ST_DONE : ST_IDLE;
        else state_next = ST_READ;
      end
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
    mem_we    = 1'b0;
    mem_waddr = cur[AW-1:0];
    mem_wdata = rdata + opnd;   // shared adder
    unique case (state)
      ST_IDLE: begin
        mem_waddr = index_lo[AW-1:0];
        mem_wdata = operand;
        mem_we    = in_valid && (func == FUNC_LOAD)
                    && ({1'b0, index_lo} < active_length);
      end
      ST_EXEC: mem_we = (op == FUNC_ADD);
      default: ;
    endcase
  end

  assign match_count = count;

  ratc_mem #(.Depth(TABLE_DEPTH), .AddrW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cur[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op    <= func;
      opnd  <= operand;
      cur   <= {1'b0, index_lo};
      last  <= hi_clip;
      count <= 11'd0;
    end else if (state == ST_EXEC) begin
      if (op == FUNC_COUNT && $signed(rdata) >= $signed(opnd)) begin
        count <= count + 11'd1;
      end
      if (cur != last) cur <= cur + 11'd1;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_count))
    else $error("result dropped");
  a_no_write_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !mem_we) else $error("write during result");

endmodule
